// ===== src/obbsat_pkg.sv =====
// Shared constants, widths and types for the oriented-box face-axis test.
package obbsat_pkg;

    localparam int COORD_WIDTH   = 21;
    localparam int ROT_FRAC_BITS = 14;
    localparam int ROT_WIDTH     = 16;
    localparam int HALF_WIDTH    = 16;
    localparam int BIAS_W        = 8;

    localparam int CENTER_FIELD_W = 63;
    localparam int HALF_FIELD_W   = 3 * HALF_WIDTH;
    localparam int ROT_FIELD_W    = 3 * ROT_WIDTH;
    localparam int BOX_W          = CENTER_FIELD_W + HALF_FIELD_W + 3 * ROT_FIELD_W;
    localparam int ITEM_W         = 2 * BOX_W;
    localparam int S_TDATA_W      = ((ITEM_W + 7) / 8) * 8;
    localparam int M_TDATA_W      = 8;

    // field offsets inside one box
    localparam int OFS_CENTER = 0;
    localparam int OFS_HALF   = CENTER_FIELD_W;
    localparam int OFS_ROT    = CENTER_FIELD_W + HALF_FIELD_W;

    // datapath widths
    localparam int PROD_RR_W = 2 * ROT_WIDTH;
    localparam int SUM_RR_W  = PROD_RR_W + 2;
    localparam int C_W       = SUM_RR_W - ROT_FRAC_BITS;
    localparam int AC_W      = C_W;
    localparam int D_W       = COORD_WIDTH + 1;
    localparam int PROD_RD_W = ROT_WIDTH + D_W;
    localparam int T_W       = PROD_RD_W + 2;
    localparam int PROD_HA_W = HALF_WIDTH + AC_W;
    localparam int PROD_TC_W = T_W + C_W;
    localparam int CMP_W     = PROD_TC_W + 2;

    localparam logic [BIAS_W-1:0] ABS_BIAS_RESET = BIAS_W'(1);

    localparam logic [2:0] AXIS_B_BASE = 3'd3;
    localparam logic [2:0] AXIS_NONE   = 3'd6;

    typedef logic signed [ROT_WIDTH-1:0] rot_t;
    typedef logic [HALF_WIDTH-1:0]       half_t;
    typedef logic signed [C_W-1:0]       cmat_t;
    typedef logic [AC_W-1:0]             acmat_t;
    typedef logic signed [T_W-1:0]       tvec_t;

    // load enables of the front stages
    typedef struct packed {
        logic ld1;
        logic ld2;
    } rel_ctrl_t;

endpackage

// ===== src/obbsat_rel.sv =====
// Front stages: relative rotation C, |C| + bias and relative offset t.
module obbsat_rel
    import obbsat_pkg::*;
(
    input  logic               clk,
    input  rel_ctrl_t          ctrl,
    input  logic [BIAS_W-1:0]  abs_bias,
    input  logic [ITEM_W-1:0]  item,
    output cmat_t              c_out  [3][3],
    output acmat_t             ac_out [3][3],
    output tvec_t              t_out  [3],
    output half_t              ha_out [3],
    output half_t              hb_out [3]
);

    rot_t                        ra [3][3];
    rot_t                        rb [3][3];
    logic signed [D_W-1:0]       d  [3];
    half_t                       ha [3];
    half_t                       hb [3];

    logic signed [PROD_RR_W-1:0] prr_reg  [3][3][3];
    logic signed [PROD_RR_W-1:0] prr_next [3][3][3];
    logic signed [PROD_RD_W-1:0] prd_reg  [3][3];
    logic signed [PROD_RD_W-1:0] prd_next [3][3];
    half_t                       ha1_reg  [3];
    half_t                       hb1_reg  [3];

    cmat_t                       c_next  [3][3];
    acmat_t                      ac_next [3][3];
    tvec_t                       t_next  [3];
    cmat_t                       c_reg   [3][3];
    acmat_t                      ac_reg  [3][3];
    tvec_t                       t_reg   [3];
    half_t                       ha2_reg [3];
    half_t                       hb2_reg [3];

    // unpack and stage 1 products
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                ra[k][j] = item[OFS_ROT + k*ROT_FIELD_W + j*ROT_WIDTH +: ROT_WIDTH];
                rb[k][j] = item[BOX_W + OFS_ROT + k*ROT_FIELD_W + j*ROT_WIDTH +: ROT_WIDTH];
            end
            d[k] = D_W'($signed(item[BOX_W + OFS_CENTER + k*COORD_WIDTH +: COORD_WIDTH]))
                 - D_W'($signed(item[OFS_CENTER + k*COORD_WIDTH +: COORD_WIDTH]));
            ha[k] = item[OFS_HALF + k*HALF_WIDTH +: HALF_WIDTH];
            hb[k] = item[BOX_W + OFS_HALF + k*HALF_WIDTH +: HALF_WIDTH];
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                    prr_next[i][j][k] = PROD_RR_W'(ra[k][i] * rb[k][j]);
                prd_next[i][k] = PROD_RD_W'(ra[k][i] * d[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld1)
        begin
            prr_reg <= prr_next;
            prd_reg <= prd_next;
            ha1_reg <= ha;
            hb1_reg <= hb;
        end
    end

    // stage 2: sums, round half up, magnitude plus bias
    always_comb
    begin
        logic signed [SUM_RR_W-1:0] s;
        logic [C_W-1:0]             m;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                s = SUM_RR_W'(prr_reg[i][j][0]) + SUM_RR_W'(prr_reg[i][j][1])
                  + SUM_RR_W'(prr_reg[i][j][2])
                  + SUM_RR_W'(1 << (ROT_FRAC_BITS - 1));
                c_next[i][j] = C_W'(s >>> ROT_FRAC_BITS);
                m = c_next[i][j][C_W-1] ? C_W'(-c_next[i][j]) : C_W'(c_next[i][j]);
                ac_next[i][j] = AC_W'(m) + AC_W'(abs_bias);
            end
            t_next[i] = T_W'(prd_reg[i][0]) + T_W'(prd_reg[i][1]) + T_W'(prd_reg[i][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld2)
        begin
            c_reg   <= c_next;
            ac_reg  <= ac_next;
            t_reg   <= t_next;
            ha2_reg <= ha1_reg;
            hb2_reg <= hb1_reg;
        end
    end

    assign c_out  = c_reg;
    assign ac_out = ac_reg;
    assign t_out  = t_reg;
    assign ha_out = ha2_reg;
    assign hb_out = hb2_reg;

endmodule

// ===== src/obb_face_axis_overlap_test.sv =====
// Top level: oriented-box face-axis overlap test, five-stage pipeline.
//
// One input beat on s_axis carries two boxes (center, half sizes, three
// orientation rows each). One output beat on m_axis gives the overlap flag
// and the first separating face axis (0-2 faces of A, 3-5 faces of B,
// 6 when no face axis separates).
// The user writes abs_bias through cfg_wr_en / cfg_wr_data only while the block is idle;
// the block does not enforce this. abs_bias is added to every |C| entry.
// Throughput: one beat per cycle while m_axis_tready does not hold the output; stages
// are rotation/offset products, their sums with rounding, the bound and projection
// products, the compares, and the output register with the axis priority encoder.
// Each stage holds a valid bit and loads when it is empty or its successor
// moves, so bubbles close up while m_axis_tready is low and s_axis_tready
// drops only once every stage holds a beat. Nothing is lost or repeated.
// Reset clears all valid bits and sets abs_bias to 1.
module obb_face_axis_overlap_test
    import obbsat_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [BIAS_W-1:0]     cfg_wr_data,    // abs_bias
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // center_a, half_a, rot_a_row0..2, center_b, half_b, rot_b_row0..2, zero pad
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // overlap, separating_axis[2:0], zero pad
    output logic [M_TDATA_W-1:0]  m_axis_tdata
);

    logic [BIAS_W-1:0] abs_bias_reg;
    logic [3:0]        vld_reg;     // stages 1..4
    logic              out_vld_reg;
    logic [4:0]        adv;         // load enable of stages 1..4 and output

    rel_ctrl_t         rel_ctrl;
    cmat_t             c  [3][3];
    acmat_t            ac [3][3];
    tvec_t             t  [3];
    half_t             ha [3];
    half_t             hb [3];

    logic [PROD_HA_W-1:0]        pa_reg [3][3];
    logic [PROD_HA_W-1:0]        pb_reg [3][3];
    logic signed [PROD_TC_W-1:0] ptc_reg [3][3];
    half_t                       ha3_reg [3];
    half_t                       hb3_reg [3];

    logic [2:0] sepa_reg, sepa_next;
    logic [2:0] sepb_reg, sepb_next;

    logic [2:0] axis_next;
    logic [2:0] axis_reg;
    logic       overlap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            abs_bias_reg <= ABS_BIAS_RESET;
        else if (cfg_wr_en)
            abs_bias_reg <= cfg_wr_data;
    end

    // stall chain
    always_comb
    begin
        adv[4] = !out_vld_reg || m_axis_tready;
        for (int s = 3; s >= 0; s--)
            adv[s] = !vld_reg[s] || adv[s+1];
    end

    assign s_axis_tready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv[0])
                vld_reg[0] <= s_axis_tvalid;
            for (int s = 1; s < 4; s++)
                if (adv[s])
                    vld_reg[s] <= vld_reg[s-1];
            if (adv[4])
                out_vld_reg <= vld_reg[3];
        end
    end

    assign rel_ctrl.ld1 = adv[0];
    assign rel_ctrl.ld2 = adv[1];

    obbsat_rel u_rel
    (
        .clk      (clk),
        .ctrl     (rel_ctrl),
        .abs_bias (abs_bias_reg),
        .item     (s_axis_tdata[ITEM_W-1:0]),
        .c_out    (c),
        .ac_out   (ac),
        .t_out    (t),
        .ha_out   (ha),
        .hb_out   (hb)
    );

    // stage 3: bound and projection products
    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    pa_reg[i][j]  <= PROD_HA_W'(hb[j]) * PROD_HA_W'(ac[i][j]);
                    pb_reg[i][j]  <= PROD_HA_W'(ha[i]) * PROD_HA_W'(ac[i][j]);
                    ptc_reg[i][j] <= PROD_TC_W'(t[i] * c[i][j]);
                end
            end
            ha3_reg <= ha;
            hb3_reg <= hb;
        end
    end

    // |t| is taken from the stage 3 copy kept alongside the products
    tvec_t t3_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv[2])
            t3_reg <= t;
    end

    function automatic logic [CMP_W-1:0] t_abs(input int idx);
        logic signed [T_W-1:0] v;
        v = t3_reg[idx];
        return v[T_W-1] ? CMP_W'(T_W'(-v)) : CMP_W'(T_W'(v));
    endfunction

    // stage 4: compares; A face i uses row i, B face j uses column j
    always_comb
    begin
        logic signed [CMP_W-1:0] p;
        logic [CMP_W-1:0]        lhs;
        logic [CMP_W-1:0]        rhs;
        for (int i = 0; i < 3; i++)
        begin
            lhs = t_abs(i);
            rhs = (CMP_W'(ha3_reg[i]) << ROT_FRAC_BITS) + CMP_W'(pa_reg[i][0])
                + CMP_W'(pa_reg[i][1]) + CMP_W'(pa_reg[i][2]);
            sepa_next[i] = lhs > rhs;

            p = CMP_W'(ptc_reg[0][i]) + CMP_W'(ptc_reg[1][i]) + CMP_W'(ptc_reg[2][i]);
            lhs = p[CMP_W-1] ? CMP_W'(-p) : CMP_W'(p);
            rhs = ((CMP_W'(pb_reg[0][i]) + CMP_W'(pb_reg[1][i]) + CMP_W'(pb_reg[2][i]))
                   << ROT_FRAC_BITS)
                + (CMP_W'(hb3_reg[i]) << (2 * ROT_FRAC_BITS));
            sepb_next[i] = lhs > rhs;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            sepa_reg <= sepa_next;
            sepb_reg <= sepb_next;
        end
    end

    // stage 5: first separating axis in order A0, B0, A1, B1, A2, B2
    always_comb
    begin
        axis_next = AXIS_NONE;
        for (int i = 2; i >= 0; i--)
        begin
            if (sepb_reg[i])
                axis_next = AXIS_B_BASE + 3'(i);
            if (sepa_reg[i])
                axis_next = 3'(i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            axis_reg    <= axis_next;
            overlap_reg <= (axis_next == AXIS_NONE);
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-4){1'b0}}, axis_reg, overlap_reg};

endmodule

// ===== src/obbsat_chk.sv =====
// Port-level checker for the face-axis overlap test, bound to the top level.
module obbsat_chk
    import obbsat_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [M_TDATA_W-1:0]  m_axis_tdata
);

    // overlap flag agrees with the axis code
    a_flag_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[3:1] == AXIS_NONE)))
        else $error("overlap flag and axis disagree");

    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:1] <= AXIS_NONE))
        else $error("axis code out of range");

    // a free output side never backs up the input
    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output ready");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped or changed under stall");

endmodule

bind obb_face_axis_overlap_test obbsat_chk u_obbsat_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
